@@ design/iff_pkg.sv @@
// iff_pkg: shared types, codes and character helpers for integer_field_formatter.
// No dependencies.
package iff_pkg;

	localparam int MAX_WIDTH    = 64;
	localparam int DIGIT_BUFFER = 32;
	localparam int DIG_MAX      = DIGIT_BUFFER - 1;

	localparam logic [2:0] FUNC_SDEC  = 3'd0;
	localparam logic [2:0] FUNC_UDEC  = 3'd1;
	localparam logic [2:0] FUNC_HEXL  = 3'd2;
	localparam logic [2:0] FUNC_HEXU  = 3'd3;
	localparam logic [2:0] FUNC_OCT   = 3'd4;
	localparam logic [2:0] FUNC_PTR   = 3'd5;

	// digit unit control
	typedef struct packed {
		logic        load;
		logic [63:0] mag;
		logic [4:0]  base;
	} dig_cmd_t;

	typedef struct packed {
		logic       done;
		logic [6:0] count;
	} dig_sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10)
			c = 8'h30 + {4'd0, d};
		else if (upper)
			c = 8'h37 + {4'd0, d};
		else
			c = 8'h57 + {4'd0, d};
		return c;
	endfunction

	function automatic logic [7:0] nil_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h28;
			3'd1: c = 8'h6e;
			3'd2: c = 8'h69;
			3'd3: c = 8'h6c;
			default: c = 8'h29;
		endcase
		return c;
	endfunction

endpackage

@@ design/iff_digits.sv @@
// iff_digits: shared digit unit that peels one digit per pass (LSB first) into a buffer.
// Depends on iff_pkg. Hex and octal take one step per digit; decimal takes eight, using a
// shift-and-add estimate of x/10 on one shared adder with a one-step remainder fix.
module iff_digits import iff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dig_cmd_t    cmd,
	input  logic [5:0]  rd_idx,
	output logic [3:0]  rd_digit,
	output dig_sts_t    sts
);

	// decimal step codes, one shared add per step
	localparam logic [2:0] DS_INIT  = 3'd0;
	localparam logic [2:0] DS_ADD4  = 3'd1;
	localparam logic [2:0] DS_ADD8  = 3'd2;
	localparam logic [2:0] DS_ADD16 = 3'd3;
	localparam logic [2:0] DS_ADD32 = 3'd4;
	localparam logic [2:0] DS_SHR3  = 3'd5;
	localparam logic [2:0] DS_REM   = 3'd6;
	localparam logic [2:0] DS_NEXT  = 3'd7;

	logic [63:0] x_q;
	logic [63:0] q_q;
	logic [4:0]  r_q;
	logic [2:0]  step_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic        dec_q;
	logic        oct_q;
	logic [3:0]  mem [0:63];

	logic [63:0] add_a, add_b, sum;
	logic [63:0] xshift;
	logic [3:0]  hdig, ddig;
	logic [4:0]  rem5;
	logic        carry;

	// q ends up equal to x/10 or one below it, so the remainder is 0..19
	always_comb begin
		add_a = q_q;
		add_b = 64'd0;
		case (step_q)
			DS_INIT: begin
				add_a = x_q >> 1;
				add_b = x_q >> 2;
			end
			DS_ADD4:  add_b = q_q >> 4;
			DS_ADD8:  add_b = q_q >> 8;
			DS_ADD16: add_b = q_q >> 16;
			DS_ADD32: add_b = q_q >> 32;
			DS_SHR3:  add_a = q_q >> 3;
			DS_NEXT:  add_b = {63'd0, carry};
			default:  ;
		endcase
	end

	assign sum = add_a + add_b;
	// remainder fits in 5 bits, so only the low bits of x - 10q are needed
	assign rem5 = x_q[4:0] - ({q_q[1:0], 3'd0} + {q_q[3:0], 1'b0});
	assign carry = (r_q > 5'd9);
	assign ddig = carry ? 4'(r_q - 5'd10) : r_q[3:0];
	assign xshift = oct_q ? (x_q >> 3) : (x_q >> 4);
	assign hdig = oct_q ? {1'b0, x_q[2:0]} : x_q[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			step_q <= DS_INIT;
		end else if (cmd.load) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
			step_q <= DS_INIT;
		end else if (run_q) begin
			if (!dec_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (xshift == 64'd0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				// wraps from DS_NEXT back to DS_INIT
				step_q <= step_q + 3'd1;
				if (step_q == DS_NEXT) begin
					cnt_q <= cnt_q + 7'd1;
					if (sum == 64'd0) begin
						run_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= cmd.mag;
			dec_q <= (cmd.base == 5'd10);
			oct_q <= (cmd.base == 5'd8);
		end else if (run_q) begin
			if (!dec_q) begin
				mem[cnt_q[5:0]] <= hdig;
				x_q <= xshift;
			end else if (step_q == DS_REM) begin
				r_q <= rem5;
			end else if (step_q == DS_NEXT) begin
				mem[cnt_q[5:0]] <= ddig;
				x_q <= sum;
			end else begin
				q_q <= sum;
			end
		end
		rd_digit <= mem[rd_idx];
	end

	assign sts = '{done: done_q, count: cnt_q};

endmodule

@@ design/integer_field_formatter.sv @@
// integer_field_formatter: printf-style integer formatting, one character per cycle.
// Depends on iff_pkg and iff_digits.
//
//  channel | handshake          | payload
//  item in | start & !busy      | func value arg_size flags field_width precision
//  char out| valid (one cycle)  | text_byte last
//
// After a word is accepted busy stays high through one load step, the digit steps in the
// shared unit (one per digit for hex, octal and pointer, eight per digit for decimal),
// one count step, one length step, then one output step per character.
// Each character shows on the ports the cycle after it is formed, so the last one is out
// in the first idle cycle. Undefined func codes are taken and emit nothing.
// Reset clears the sequencer. The receiver cannot stall: characters go out one per cycle.
module integer_field_formatter import iff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [63:0] value,
	input  logic [1:0]  arg_size,
	input  logic        flag_left,
	input  logic        flag_zero,
	input  logic        flag_plus,
	input  logic        flag_space,
	input  logic        flag_alt,
	input  logic [6:0]  field_width,
	input  logic        precision_given,
	input  logic [4:0]  precision,
	output logic        valid,
	output logic [7:0]  text_byte,
	output logic        last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIG  = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0]  state_q;
	logic [63:0] mag_q;
	logic [4:0]  base_q;
	logic        upper_q, left_q, zpad_q, nil_q, nodig_q, pg_q;
	logic [4:0]  prec_q;
	logic [6:0]  width_q;
	logic [7:0]  pre0_q, pre1_q;
	logic [1:0]  plen_q;
	logic [6:0]  rl_q, lead_q, dlen_q, k_q;
	logic        launch_q;

	dig_cmd_t cmd;
	dig_sts_t sts;
	logic [5:0] rd_idx;
	logic [3:0] rd_digit;

	iff_digits u_dig (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rd_idx(rd_idx),
		.rd_digit(rd_digit), .sts(sts));

	assign busy = (state_q != ST_IDLE);

	// capture decode
	logic [63:0] msk, m0, mg;
	logic        neg;
	always_comb begin
		case (arg_size)
			2'd0: msk = 64'hff;
			2'd1: msk = 64'hffff;
			2'd2: msk = 64'hffff_ffff;
			default: msk = '1;
		endcase
		m0 = value & msk;
		case (arg_size)
			2'd0: neg = m0[7];
			2'd1: neg = m0[15];
			2'd2: neg = m0[31];
			default: neg = m0[63];
		endcase
		neg = neg && (func == FUNC_SDEC);
		mg = neg ? ((~m0 + 64'd1) & msk) : m0;
		if (neg && mg == 64'd0) mg = msk ^ (msk >> 1);
		if (func == FUNC_PTR) mg = value;
	end

	// sign or alternate prefix
	logic [1:0] plen_n;
	logic [7:0] pre0_n, pre1_n;
	always_comb begin
		plen_n = 2'd0;
		pre0_n = 8'h30;
		pre1_n = 8'h78;
		if (func == FUNC_PTR) begin
			if (value != 64'd0) plen_n = 2'd2;
		end else if (func == FUNC_SDEC) begin
			if (neg) begin plen_n = 2'd1; pre0_n = 8'h2d; end
			else if (flag_plus) begin plen_n = 2'd1; pre0_n = 8'h2b; end
			else if (flag_space) begin plen_n = 2'd1; pre0_n = 8'h20; end
		end else if (flag_alt && mg != 64'd0) begin
			if (func == FUNC_OCT) plen_n = 2'd1;
			else if (func != FUNC_UDEC) begin
				plen_n = 2'd2;
				if (func == FUNC_HEXU) pre1_n = 8'h58;
			end
		end
	end

	assign cmd = '{load: launch_q, mag: mag_q, base: base_q};

	// digit count, capped
	logic [6:0] tot;
	always_comb begin
		tot = (pg_q && {2'd0, prec_q} > sts.count) ? {2'd0, prec_q} : sts.count;
		if (tot > 7'(DIG_MAX)) tot = 7'(DIG_MAX);
	end

	logic [6:0] body, padv, n_chr;
	always_comb begin
		body = {5'd0, plen_q} + dlen_q;
		padv = (width_q > body) ? width_q - body : 7'd0;
		// body + pad never exceeds 64 + prefix, clamp to 64
		n_chr = ((body + padv) > 7'd64) ? 7'd64 : body + padv;
	end

	// section boundaries, stable from the length cycle on
	logic [6:0] lpad, zpadv, b1, b2, b3, b4;
	always_comb begin
		lpad = (!left_q && !zpad_q) ? padv : 7'd0;
		zpadv = zpad_q ? padv : 7'd0;
		b1 = lpad;
		b2 = lpad + {5'd0, plen_q};
		b3 = b2 + zpadv;
		b4 = b3 + dlen_q;
	end

	// character at position k_q; rd_digit is for index computed last cycle
	logic [6:0] kn;
	logic [6:0] didx;
	always_comb begin
		kn = (state_q == ST_OUT) ? k_q + 7'd1 : 7'd0;
		// digit section index of kn relative to raw digits (MSB first)
		didx = kn - b3 - lead_q;
		rd_idx = 6'(rl_q - 7'd1 - didx);
	end

	logic [7:0] ch;
	always_comb begin
		if (k_q < b1) ch = 8'h20;
		else if (k_q < b2) ch = (k_q == b1) ? pre0_q : pre1_q;
		else if (k_q < b3) ch = 8'h30;
		else if (k_q < b4) begin
			if (nil_q) ch = nil_char(3'(k_q - b3));
			else if (k_q < b3 + lead_q) ch = 8'h30;
			else ch = digit_char(rd_digit, upper_q);
		end else ch = 8'h20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launch_q <= 1'b0;
			valid <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (start && func <= FUNC_PTR) begin
					state_q <= ST_DIG;
					launch_q <= 1'b1;
				end
				ST_DIG: if (sts.done && !launch_q) state_q <= ST_LEN;
				ST_LEN: state_q <= (n_chr == 7'd0) ? ST_IDLE : ST_OUT;
				ST_OUT: begin
					valid <= 1'b1;
					if (k_q == n_chr - 7'd1) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q <= mg;
				width_q <= (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
				left_q <= flag_left;
				pg_q <= precision_given && func != FUNC_PTR;
				prec_q <= precision;
				upper_q <= (func == FUNC_HEXU);
				nil_q <= (func == FUNC_PTR) && value == 64'd0;
				zpad_q <= flag_zero && !flag_left && !(precision_given && func != FUNC_PTR)
					&& !(func == FUNC_PTR && value == 64'd0);
				nodig_q <= precision_given && precision == 5'd0 && mg == 64'd0
					&& func != FUNC_PTR;
				base_q <= (func == FUNC_HEXL || func == FUNC_HEXU || func == FUNC_PTR)
					? 5'd16 : (func == FUNC_OCT) ? 5'd8 : 5'd10;
				plen_q <= plen_n;
				pre0_q <= pre0_n;
				pre1_q <= pre1_n;
			end
			ST_DIG: if (sts.done && !launch_q) begin
				rl_q <= sts.count;
				if (nil_q) begin
					dlen_q <= 7'd5; lead_q <= 7'd0;
				end else if (nodig_q) begin
					dlen_q <= 7'd0; lead_q <= 7'd0;
				end else begin
					// raw digits never exceed the cap, so only precision zeros are cut
					dlen_q <= tot;
					lead_q <= (tot > sts.count) ? tot - sts.count : 7'd0;
				end
			end
			ST_LEN: begin
				k_q <= 7'd0;
			end
			ST_OUT: begin
				k_q <= k_q + 7'd1;
				text_byte <= ch;
				last <= (k_q == n_chr - 7'd1);
			end
			default: ;
		endcase
	end

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n) valid |-> $past(busy))
		else $error("char emitted while idle");
	a_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !valid || $past(valid))
		else $error("char after idle");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("char after last");

endmodule

@@ bench/iff_checker.sv @@
// iff_checker: predicts the formatted text of each accepted word and checks the char stream.
// Depends on iff_pkg; watches the ports of integer_field_formatter.
module iff_checker import iff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  func,
	input  logic [63:0] value,
	input  logic [1:0]  arg_size,
	input  logic        flag_left,
	input  logic        flag_zero,
	input  logic        flag_plus,
	input  logic        flag_space,
	input  logic        flag_alt,
	input  logic [6:0]  field_width,
	input  logic        precision_given,
	input  logic [4:0]  precision,
	input  logic        valid,
	input  logic [7:0]  text_byte,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          chars_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} fmt_char_t;

	fmt_char_t text_q[$];

	function automatic logic [7:0] hex_ch(input logic [3:0] d, input logic up);
		if (d < 10) return 8'h30 + d;
		return (up ? 8'h37 : 8'h57) + d;
	endfunction

	task automatic format_field();
		logic [7:0] pre[2];
		logic [7:0] dig[$];
		logic [7:0] rawd[$];
		logic [7:0] txt[$];
		int plen, w, bits, base, total, pad, n;
		logic [63:0] mask, mag;
		logic zp, zf, pg, up;
		plen = 0; zf = flag_zero; pg = precision_given;
		if (func > FUNC_PTR) return;
		w = field_width > MAX_WIDTH ? MAX_WIDTH : field_width;
		up = (func == FUNC_HEXU);
		if (func == FUNC_PTR) begin
			pg = 0;
			if (value == 0) begin
				dig = '{8'h28, 8'h6e, 8'h69, 8'h6c, 8'h29};
				zf = 0;
			end else begin
				pre[0] = "0"; pre[1] = "x"; plen = 2;
				mag = value;
				do begin rawd.push_front(hex_ch(mag[3:0], 0)); mag = mag >> 4; end
				while (mag != 0);
				dig = rawd;
			end
		end else begin
			bits = 8 << arg_size;
			mask = bits >= 64 ? '1 : ((64'd1 << bits) - 1);
			mag = value & mask;
			base = 10;
			if (func == FUNC_SDEC) begin
				if (mag[bits-1]) begin
					mag = (~mag + 1) & mask;
					pre[plen++] = "-";
				end else if (flag_plus) pre[plen++] = "+";
				else if (flag_space) pre[plen++] = " ";
			end else if (func == FUNC_HEXL || func == FUNC_HEXU) base = 16;
			else if (func == FUNC_OCT) base = 8;
			if (flag_alt && mag != 0) begin
				if (base == 16) begin
					pre[0] = "0"; pre[1] = up ? "X" : "x"; plen = 2;
				end else if (base == 8) begin
					pre[0] = "0"; plen = 1;
				end
			end
			if (!(pg && precision == 0 && mag == 0)) begin
				do begin
					rawd.push_front(hex_ch(4'(mag % base), up));
					mag = mag / base;
				end while (mag != 0);
				total = pg && precision > rawd.size() ? precision : rawd.size();
				if (total > DIG_MAX) total = DIG_MAX;
				for (int i = rawd.size(); i < total; i++) dig.push_back("0");
				for (int i = 0; i < rawd.size() && dig.size() < total; i++)
					dig.push_back(rawd[i]);
			end
		end
		zp = zf && !flag_left && !pg;
		pad = w > plen + dig.size() ? w - plen - dig.size() : 0;
		if (!flag_left && !zp) repeat (pad) txt.push_back(" ");
		for (int i = 0; i < plen; i++) txt.push_back(pre[i]);
		if (zp) repeat (pad) txt.push_back("0");
		foreach (dig[i]) txt.push_back(dig[i]);
		if (flag_left) repeat (pad) txt.push_back(" ");
		n = txt.size() > 64 ? 64 : txt.size();
		for (int k = 0; k < n; k++) text_q.push_back('{txt[k], k == n - 1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			chars_seen <= 0;
		end else begin
			// output side first: a char cannot come from a word accepted this edge
			if (valid) begin
				chars_seen <= chars_seen + 1;
				if (text_q.size() == 0) begin
					$display("%0t: unexpected char expected none actual %h last %b",
						$time, text_byte, last);
					errors <= errors + 1;
				end else begin
					fmt_char_t e;
					e = text_q.pop_front();
					if (e.ch !== text_byte || e.lst !== last) begin
						$display("%0t: mismatch expected %h/%b actual %h/%b",
							$time, e.ch, e.lst, text_byte, last);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy) format_field();
		end
	end

	assign pending = text_q.size();
endmodule

@@ bench/tb_integer_field_formatter.sv @@
// tb_integer_field_formatter: directed and random words into integer_field_formatter.
// Depends on iff_pkg, iff_checker and the design.
module tb_integer_field_formatter import iff_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0, arst_n = 0, start = 0;
	logic        busy, valid, last;
	logic [2:0]  func = 0;
	logic [63:0] value = 0;
	logic [1:0]  arg_size = 0;
	logic        flag_left = 0, flag_zero = 0, flag_plus = 0, flag_space = 0, flag_alt = 0;
	logic [6:0]  field_width = 0;
	logic        precision_given = 0;
	logic [4:0]  precision = 0;
	logic [7:0]  text_byte;
	int          errors, pending, chars_seen, idle_pct, words;
	longint      cycles = 0;

	integer_field_formatter u_top (.*);
	iff_checker u_chk (.*);

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("integer_field_formatter test failed");
			$finish;
		end
	end

	// start stays high from one word to the next unless the sender idles
	task automatic send(input logic [2:0] f, input logic [63:0] v, input logic [1:0] sz,
		input logic [4:0] fl, input logic [6:0] w, input logic pg, input logic [4:0] p);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1; func <= f; value <= v; arg_size <= sz;
		{flag_left, flag_zero, flag_plus, flag_space, flag_alt} <= fl;
		field_width <= w; precision_given <= pg; precision <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		words++;
	endtask

	function automatic logic [63:0] rnd_val();
		case ($urandom_range(4))
			0: return 64'd0;
			1: return '1;
			2: return 64'h1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		words = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, each conversion, nil pointer, empty zero, bad codes
		send(FUNC_SDEC, 64'h80, 2'd0, 5'b00000, 7'd0, 1'b0, 5'd0);
		send(FUNC_SDEC, 64'h8000_0000_0000_0000, 2'd3, 5'b00100, 7'd0, 1'b0, 5'd0);
		send(FUNC_SDEC, 64'h7fff, 2'd1, 5'b00110, 7'd10, 1'b0, 5'd0);
		send(FUNC_SDEC, 64'd5, 2'd2, 5'b00010, 7'd8, 1'b1, 5'd4);
		send(FUNC_UDEC, '1, 2'd3, 5'b01000, 7'd64, 1'b0, 5'd0);
		send(FUNC_HEXL, 64'hbeef, 2'd1, 5'b00001, 7'd12, 1'b0, 5'd0);
		send(FUNC_HEXU, 64'hbeef, 2'd1, 5'b01001, 7'd12, 1'b0, 5'd0);
		send(FUNC_OCT, 64'd8, 2'd0, 5'b10001, 7'd6, 1'b0, 5'd0);
		send(FUNC_OCT, 64'd0, 2'd2, 5'b00001, 7'd0, 1'b1, 5'd0);
		send(FUNC_HEXL, 64'd0, 2'd2, 5'b00001, 7'd3, 1'b1, 5'd0);
		send(FUNC_PTR, 64'd0, 2'd0, 5'b01000, 7'd9, 1'b1, 5'd5);
		send(FUNC_PTR, 64'h1234, 2'd0, 5'b01110, 7'd10, 1'b1, 5'd9);
		send(FUNC_PTR, '1, 2'd0, 5'b10000, 7'd20, 1'b0, 5'd0);
		send(FUNC_UDEC, 64'd7, 2'd0, 5'b00000, 7'd127, 1'b1, 5'd31);
		send(FUNC_HEXL, 64'd1, 2'd3, 5'b11111, 7'd100, 1'b1, 5'd31);
		send(3'd6, '1, 2'd3, 5'b11111, 7'd20, 1'b1, 5'd3);
		send(3'd7, 64'd0, 2'd0, 5'b00000, 7'd0, 1'b0, 5'd0);
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = ph == 0 ? 30 : ph == 1 ? 83 : 0;
			repeat (65) begin
				logic [6:0] w;
				w = $urandom_range(9) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(16));
				send(3'($urandom_range(15) == 0 ? $urandom_range(7) : $urandom_range(5)),
					rnd_val(), 2'($urandom), 5'($urandom), w, 1'($urandom),
					5'($urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(6)));
			end
		end
		start <= 0;
		while (pending != 0 || busy) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d words in, %0d chars checked, all conversions and flag mixes", words,
			chars_seen);
		if (errors == 0 && pending == 0)
			$display("integer_field_formatter test passed");
		else
			$display("integer_field_formatter test failed");
		$finish;
	end
endmodule
